### hw/rtl/lru_page_replacement_order_assert.svh
// assertion macros shared by the lru replacement stack rtl
`ifndef LRU_PAGE_REPLACEMENT_ORDER_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ORDER_ASSERT_SVH

// clocked check, switched off while reset is high
`define LRUPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds during reset
`define LRUPR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/lrupr_pkg.sv
// types and constants of the lru replacement stack
package lrupr_pkg;

  localparam int DEPTH     = 16;
  localparam int PAGE_BITS = 20;
  localparam int SLOT_W    = $clog2(DEPTH);
  localparam int COUNT_W   = $clog2(DEPTH + 1);
  localparam int OCC_W     = 5;

  localparam logic FUNC_TOUCH = 1'b0;
  localparam logic FUNC_EVICT = 1'b1;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [COUNT_W-1:0]   count_t;

  // request beat
  typedef struct packed {
    logic  func;
    page_t page_id;
  } req_t;

  // response beat
  typedef struct packed {
    logic             victim_valid;
    page_t            victim_page;
    logic             was_present;
    logic             overflow;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    page_t  key;
    count_t count;
    slot_t  last_slot;
    logic   commit;
  } cell_bus_t;

  // handed from one cell to the next
  typedef struct packed {
    logic  hit_seen;
    page_t victim;
  } cell_link_t;

endpackage

### hw/rtl/lru_page_replacement_order.sv
// LRU replacement stack: a row of DEPTH cells keeps resident pages most recent
// first. A touch searches every cell in the same cycle, and the cells in front
// of the hit (or all listed cells for a new page) shift back one slot while the
// page enters slot 0; an evict reports the last listed page. Each beat is
// handled by a combinational search and its response is registered, so the block
// takes one beat per cycle whenever the response side keeps up; the compare
// and hit chain in that combinational path runs through all DEPTH cells.
// A new page touched while the stack is full is dropped and flagged overflow.
module lru_page_replacement_order
  import lrupr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

`include "lru_page_replacement_order_assert.svh"

  count_t     count;
  count_t     count_next;
  cell_bus_t  bus;
  page_t      pages [DEPTH];
  cell_link_t links [DEPTH+1];
  logic       accept;
  logic       touch;
  logic       evict;
  logic       found;
  logic       full;
  logic       empty;
  rsp_t       rsp_next;

  // handshake: output register frees as it is taken
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign touch     = accept && (req.func == FUNC_TOUCH);
  assign evict     = accept && (req.func == FUNC_EVICT);

  assign full  = count == COUNT_W'(DEPTH);
  assign empty = count == '0;
  assign found = links[DEPTH].hit_seen;

  // broadcast to the cells
  assign bus.key       = req.page_id;
  assign bus.count     = count;
  assign bus.last_slot = SLOT_W'(count - COUNT_W'(1));
  assign bus.commit    = touch && (found || !full);

  assign links[0] = '0;

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lrupr_cell u_cell (
      .clk       (clk),
      .slot      (SLOT_W'(i)),
      .bus       (bus),
      .prev_page ((i == 0) ? req.page_id : pages[(i == 0) ? 0 : i-1]),
      .link_in   (links[i]),
      .page      (pages[i]),
      .link_out  (links[i+1])
    );
  end

  // list length
  always_comb begin
    count_next = count;
    if (touch && !found && !full) begin
      count_next = count + COUNT_W'(1);
    end else if (evict && !empty) begin
      count_next = count - COUNT_W'(1);
    end
  end

  // response contents
  always_comb begin
    rsp_next.victim_valid = evict && !empty;
    rsp_next.victim_page  = (evict && !empty) ? links[DEPTH].victim : '0;
    rsp_next.was_present  = touch && found;
    rsp_next.overflow     = touch && !found && full;
    rsp_next.occupancy    = OCC_W'(count_next);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  `LRUPR_ASSERT(a_count_bound, count <= COUNT_W'(DEPTH), "list length above depth")
  `LRUPR_ASSERT(a_evict_shrinks, evict && !empty |=> count == $past(count) - COUNT_W'(1), "evict did not shrink list")
  `LRUPR_ASSERT(a_victim_flags, rsp_valid && rsp.victim_valid |-> !rsp.was_present && !rsp.overflow, "evict response carries touch flags")
  `LRUPR_ASSERT(a_overflow_keeps, touch && !found && full |=> count == COUNT_W'(DEPTH), "overflow changed list length")

endmodule

### hw/rtl/lrupr_cell.sv
// one slot of the recency stack: holds a page, compares, shifts from its neighbor
module lrupr_cell
  import lrupr_pkg::*;
(
  input  logic       clk,
  input  slot_t      slot,
  input  cell_bus_t  bus,
  input  page_t      prev_page,
  input  cell_link_t link_in,
  output page_t      page,
  output cell_link_t link_out
);

  logic live;
  logic hit;
  logic shift;

  // slot holds a listed page and it matches the key
  assign live = COUNT_W'(slot) < bus.count;
  assign hit  = live && (page == bus.key);

  // shift in while no hit lies in front and the slot is within the list or just past its end
  assign shift = bus.commit && !link_in.hit_seen && (COUNT_W'(slot) <= bus.count);

  // hit chain and victim chain toward the tail
  assign link_out.hit_seen = link_in.hit_seen || hit;
  assign link_out.victim   = (slot == bus.last_slot) ? page : link_in.victim;

  // page storage
  always_ff @(posedge clk) begin
    if (shift) begin
      page <= prev_page;
    end
  end

endmodule
